// File: hdl/pli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// Shared sizes, opcodes, status codes, cell commands, chain actions and states of the positional list.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DEPTH     = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int VAL_W     = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 6;
  localparam int STAT_W    = 3;
  localparam int EIDX_W    = 6;
  localparam int ECNT_W    = 7;
  localparam int POS_CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_END   = 3'd3,
    OP_INS_AT    = 3'd4,
    OP_DUMP      = 3'd5
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_LOW    = 3'd2,
    ST_BEYOND = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  // what one cell loads on the next edge
  typedef enum logic [2:0] {
    CC_HOLD  = 3'd0,
    CC_LEFT  = 3'd1,
    CC_RIGHT = 3'd2,
    CC_LOAD  = 3'd3,
    CC_WRAP  = 3'd4
  } cell_cmd_t;

  // chain-wide action decided by the controller
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_ROTATE = 2'd3
  } chain_act_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } fsm_t;

endpackage
`default_nettype wire

// File: hdl/pli_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_in_if
// Request channel of the positional list: valid/ready with one operation.
// ----------------------------------------------------------------------------
interface pli_in_if;
  logic                          valid;
  logic                          ready;
  logic [pli_pkg::OP_W-1:0]      opcode;
  logic [pli_pkg::POS_W-1:0]     position;
  logic signed [pli_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/pli_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_out_if
// Result channel of the positional list: valid/ready with one result.
// ----------------------------------------------------------------------------
interface pli_out_if;
  logic                             valid;
  logic                             ready;
  logic [pli_pkg::STAT_W-1:0]       status;
  logic signed [pli_pkg::VAL_W-1:0] entry_value;
  logic [pli_pkg::EIDX_W-1:0]       entry_index;
  logic [pli_pkg::ECNT_W-1:0]       entry_count;
  logic                             last;

  modport source (output valid, output status, output entry_value,
                  output entry_index, output entry_count, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_value,
                  input entry_index, input entry_count, input last,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/positional_list_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// update requests: result registered in the cycle after acceptance, one request per cycle
//   while the result register is drained every cycle
// dump: one result per entry, registered from the dump state at one per cycle while
//   drained; the list rotates through the cell chain and comes back intact
// reset clears the entry count and the control; cell values stay undefined
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Bounded ordered list kept as a row of cells with insert, delete and dump.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pli_in_if.sink     in_ch,
  pli_out_if.source  out_ch
);

  localparam int DEPTH = pli_pkg::DEPTH;
  localparam int CNT_W = pli_pkg::CNT_W;
  localparam int IDX_W = pli_pkg::IDX_W;
  localparam int CMP_W = pli_pkg::POS_CMP_W;

  pli_pkg::fsm_t                    state_r, state_nxt;
  logic [CNT_W-1:0]                 occ_r, occ_nxt;
  logic [IDX_W-1:0]                 dump_idx_r, dump_idx_nxt;
  logic                             out_valid_r, out_valid_nxt;
  pli_pkg::status_t                 out_status_r, out_status_nxt;
  logic signed [pli_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [pli_pkg::EIDX_W-1:0]       out_index_r, out_index_nxt;
  logic [pli_pkg::ECNT_W-1:0]       out_count_r, out_count_nxt;
  logic                             out_last_r, out_last_nxt;

  pli_pkg::chain_act_t              act;
  logic [IDX_W-1:0]                 ins_idx;
  logic signed [pli_pkg::VAL_W-1:0] cell_val [DEPTH];
  pli_pkg::cell_cmd_t               cell_cmd [DEPTH];

  logic accept;
  logic out_free;
  logic full;
  logic empty;
  logic dump_last;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == pli_pkg::FSM_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign full         = (occ_r == CNT_W'(DEPTH));
  assign empty        = (occ_r == '0);
  assign dump_last    = (CNT_W'(dump_idx_r) + CNT_W'(1)) == occ_r;

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    act            = pli_pkg::ACT_NONE;
    ins_idx        = '0;

    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pli_pkg::ST_OK;
      out_value_nxt  = '0;
      out_index_nxt  = '0;
      out_last_nxt   = 1'b1;
      unique case (in_ch.opcode)
        pli_pkg::OP_INS_FRONT: begin
          if (full) begin
            out_status_nxt = pli_pkg::ST_FULL;
          end else begin
            act     = pli_pkg::ACT_INSERT;
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        pli_pkg::OP_INS_END: begin
          if (full) begin
            out_status_nxt = pli_pkg::ST_FULL;
          end else begin
            act     = pli_pkg::ACT_INSERT;
            ins_idx = IDX_W'(occ_r);
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        pli_pkg::OP_DEL_FRONT: begin
          if (empty) begin
            out_status_nxt = pli_pkg::ST_EMPTY;
          end else begin
            act     = pli_pkg::ACT_DELETE;
            occ_nxt = occ_r - CNT_W'(1);
          end
        end
        pli_pkg::OP_DEL_END: begin
          if (empty) begin
            out_status_nxt = pli_pkg::ST_EMPTY;
          end else begin
            occ_nxt = occ_r - CNT_W'(1);
          end
        end
        pli_pkg::OP_INS_AT: begin
          // position checks take priority over the full check
          priority if (in_ch.position == '0) begin
            out_status_nxt = pli_pkg::ST_LOW;
          end else if (CMP_W'(in_ch.position) > CMP_W'(occ_r) + CMP_W'(1)) begin
            out_status_nxt = pli_pkg::ST_BEYOND;
          end else if (full) begin
            out_status_nxt = pli_pkg::ST_FULL;
          end else begin
            act     = pli_pkg::ACT_INSERT;
            ins_idx = IDX_W'(in_ch.position - pli_pkg::POS_W'(1));
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        pli_pkg::OP_DUMP: begin
          if (empty) begin
            out_status_nxt = pli_pkg::ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            dump_idx_nxt  = '0;
            state_nxt     = pli_pkg::FSM_DUMP;
          end
        end
        default: begin
        end
      endcase
      out_count_nxt = pli_pkg::ECNT_W'(occ_nxt);
    end else if (state_r == pli_pkg::FSM_DUMP && out_free) begin
      // head of the chain goes out, the rest rotates toward it
      out_valid_nxt  = 1'b1;
      out_status_nxt = pli_pkg::ST_OK;
      out_value_nxt  = cell_val[0];
      out_index_nxt  = pli_pkg::EIDX_W'(dump_idx_r);
      out_count_nxt  = pli_pkg::ECNT_W'(occ_r);
      out_last_nxt   = dump_last;
      act            = pli_pkg::ACT_ROTATE;
      dump_idx_nxt   = dump_idx_r + IDX_W'(1);
      if (dump_last) begin
        state_nxt = pli_pkg::FSM_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pli_pkg::FSM_IDLE;
      occ_r       <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_value = out_value_r;
  assign out_ch.entry_index = out_index_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.last        = out_last_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [pli_pkg::VAL_W-1:0] left_v;
    logic signed [pli_pkg::VAL_W-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = in_ch.value;
    end else begin : g_body
      assign left_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_v = cell_val[0];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end

    always_comb begin
      cell_cmd[i] = pli_pkg::CC_HOLD;
      unique case (act)
        pli_pkg::ACT_INSERT: begin
          if (IDX_W'(i) == ins_idx) begin
            cell_cmd[i] = pli_pkg::CC_LOAD;
          end else if (IDX_W'(i) > ins_idx) begin
            cell_cmd[i] = pli_pkg::CC_LEFT;
          end
        end
        pli_pkg::ACT_DELETE: begin
          if (CNT_W'(i) + CNT_W'(1) < occ_r) begin
            cell_cmd[i] = pli_pkg::CC_RIGHT;
          end
        end
        pli_pkg::ACT_ROTATE: begin
          if (CNT_W'(i) + CNT_W'(1) < occ_r) begin
            cell_cmd[i] = pli_pkg::CC_RIGHT;
          end else if (CNT_W'(i) + CNT_W'(1) == occ_r) begin
            cell_cmd[i] = pli_pkg::CC_WRAP;
          end
        end
        default: begin
        end
      endcase
    end

    pli_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd[i]),
      .left_val  (left_v),
      .right_val (right_v),
      .wrap_val  (cell_val[0]),
      .load_val  (in_ch.value),
      .val       (cell_val[i])
    );
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pli_pkg::FSM_DUMP |-> occ_r != '0)
    else $error("dump running on an empty list");

  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pli_pkg::FSM_DUMP |-> !in_ch.ready)
    else $error("request taken during dump");

  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.opcode != pli_pkg::OP_DUMP |=> out_ch.valid && out_ch.last)
    else $error("update request gave no single result");
`endif

endmodule
`default_nettype wire

// File: hdl/pli_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_cell
// One list slot: holds a value, or takes it from a neighbor, the head or the
// new request value.
// ----------------------------------------------------------------------------
module pli_cell (
  input  wire logic                             clk,
  input  wire pli_pkg::cell_cmd_t               cmd,
  input  wire logic signed [pli_pkg::VAL_W-1:0] left_val,
  input  wire logic signed [pli_pkg::VAL_W-1:0] right_val,
  input  wire logic signed [pli_pkg::VAL_W-1:0] wrap_val,
  input  wire logic signed [pli_pkg::VAL_W-1:0] load_val,
  output logic signed [pli_pkg::VAL_W-1:0]      val
);

  logic signed [pli_pkg::VAL_W-1:0] val_r;
  logic signed [pli_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    unique case (cmd)
      pli_pkg::CC_LEFT:  val_nxt = left_val;
      pli_pkg::CC_RIGHT: val_nxt = right_val;
      pli_pkg::CC_LOAD:  val_nxt = load_val;
      pli_pkg::CC_WRAP:  val_nxt = wrap_val;
      default:           val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

// File: verif/positional_list_insert_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Sends list operations through the request channel. The bench keeps its own
// copy of the list, works out every result each request should give and
// checks the returned results in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;

  localparam logic [pli_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [pli_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 238;
  localparam int QUIET_ITEMS  = 40;
  localparam int CHUNK        = 30;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [pli_pkg::STAT_W-1:0] status;
    logic [pli_pkg::VAL_W-1:0]  value;
    logic [pli_pkg::EIDX_W-1:0] index;
    logic [pli_pkg::ECNT_W-1:0] count;
    logic                       last;
  } list_result_t;

  class list_scoreboard;
    logic [pli_pkg::VAL_W-1:0] cells [pli_pkg::DEPTH];
    int unsigned               count;
    list_result_t              expected_q[$];
    int unsigned               mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function void push_result(logic [pli_pkg::STAT_W-1:0] st,
                              logic [pli_pkg::VAL_W-1:0] v,
                              int unsigned idx, bit last);
      list_result_t r;
      r.status = st;
      r.value  = v;
      r.index  = idx[pli_pkg::EIDX_W-1:0];
      r.count  = count[pli_pkg::ECNT_W-1:0];
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    function void put_at(int unsigned p, logic [pli_pkg::VAL_W-1:0] v);
      for (int unsigned i = count; i > p; i--) cells[i] = cells[i-1];
      cells[p] = v;
      count++;
    endfunction

    function void note_request(logic [pli_pkg::OP_W-1:0] op,
                               logic [pli_pkg::POS_W-1:0] pos,
                               logic [pli_pkg::VAL_W-1:0] v);
      logic [pli_pkg::STAT_W-1:0] st;
      st = pli_pkg::ST_OK;
      unique case (op)
        pli_pkg::OP_INS_FRONT: begin
          if (count >= pli_pkg::DEPTH) st = pli_pkg::ST_FULL;
          else put_at(0, v);
        end
        pli_pkg::OP_INS_END: begin
          if (count >= pli_pkg::DEPTH) st = pli_pkg::ST_FULL;
          else put_at(count, v);
        end
        pli_pkg::OP_DEL_FRONT: begin
          if (count == 0) begin
            st = pli_pkg::ST_EMPTY;
          end else begin
            for (int unsigned i = 0; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        pli_pkg::OP_DEL_END: begin
          if (count == 0) st = pli_pkg::ST_EMPTY;
          else count--;
        end
        pli_pkg::OP_INS_AT: begin
          // position checks win over the full check
          if (pos < 1) st = pli_pkg::ST_LOW;
          else if (pos > count + 1) st = pli_pkg::ST_BEYOND;
          else if (count >= pli_pkg::DEPTH) st = pli_pkg::ST_FULL;
          else put_at(pos - 1, v);
        end
        pli_pkg::OP_DUMP: begin
          if (count == 0) begin
            push_result(pli_pkg::ST_EMPTY, '0, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++)
              push_result(pli_pkg::ST_OK, cells[i], i, i + 1 == count);
          end
          return;
        end
        default: ;
      endcase
      push_result(st, '0, 0, 1'b1);
    endfunction

    function void flag(string what, list_result_t want, list_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected st %0d val %0d idx %0d cnt %0d last %0b",
                 $time, what, want.status, $signed(want.value), want.index,
                 want.count, want.last,
                 " / got st %0d val %0d idx %0d cnt %0d last %0b",
                 got.status, $signed(got.value), got.index, got.count, got.last);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.value !== want.value ||
          got.index !== want.index || got.count !== want.count ||
          got.last !== want.last)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  bit             quiet = 1'b0;
  bit             tx_gaps = 1'b1;
  int unsigned    cycles = 0;
  list_scoreboard sb = new();

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  positional_list_insert_delete dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("positional_list_insert_delete_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [pli_pkg::VAL_W-1:0] rand_value();
    unique case ($urandom_range(0, 11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(logic [pli_pkg::OP_W-1:0] op, logic [pli_pkg::POS_W-1:0] pos,
                       logic [pli_pkg::VAL_W-1:0] v);
    if (!quiet && tx_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.position <= pos;
    in_ch.value    <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(op, pos, v);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold once results are flowing
  initial begin
    int unsigned  stall;
    int unsigned  seen;
    int unsigned  rx_cycles;
    bit           held;
    list_result_t got;
    stall = 0;
    seen = 0;
    rx_cycles = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status = out_ch.status;
        got.value  = out_ch.entry_value;
        got.index  = out_ch.entry_index;
        got.count  = out_ch.entry_count;
        got.last   = out_ch.last;
        sb.check_result(got);
        seen++;
      end
      if (!held && seen >= 40) begin
        held = 1'b1;
        stall = LONG_HOLD;
      end else if (stall == 0 && !quiet && (rx_cycles / 256) % 3 != 2 &&
                   $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned                mode;
    int unsigned                r;
    logic [pli_pkg::OP_W-1:0]   op;
    logic [pli_pkg::POS_W-1:0]  pos;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= '0;
    in_ch.position <= '0;
    in_ch.value    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners, then inserts at the ends and at positions, spare opcodes and a dump
    issue(pli_pkg::OP_DUMP, '0, rand_value());
    issue(pli_pkg::OP_DEL_FRONT, '0, rand_value());
    issue(pli_pkg::OP_DEL_END, '0, rand_value());
    issue(pli_pkg::OP_INS_AT, 6'd0, rand_value());
    issue(pli_pkg::OP_INS_AT, 6'd2, rand_value());
    issue(pli_pkg::OP_INS_AT, 6'd1, 32'h8000_0000);
    issue(pli_pkg::OP_INS_FRONT, 6'd0, 32'h7fff_ffff);
    issue(pli_pkg::OP_INS_END, 6'h3f, 32'hffff_ffff);
    issue(pli_pkg::OP_INS_AT, 6'd4, 32'h0000_0000);
    issue(pli_pkg::OP_INS_AT, 6'd2, 32'h5555_5555);
    issue(pli_pkg::OP_INS_AT, 6'd63, 32'haaaa_aaaa);
    issue(OP_SPARE_A, 6'd5, rand_value());
    issue(OP_SPARE_B, 6'd10, rand_value());
    issue(pli_pkg::OP_DUMP, '0, rand_value());
    // fill up, hit the full list, then dump and delete from both ends
    while (sb.count < pli_pkg::DEPTH)
      issue($urandom_range(0, 1) ? pli_pkg::OP_INS_FRONT : pli_pkg::OP_INS_AT,
            pli_pkg::POS_W'($urandom_range(1, sb.count + 1)), rand_value());
    issue(pli_pkg::OP_INS_FRONT, '0, rand_value());
    issue(pli_pkg::OP_INS_END, '0, rand_value());
    issue(pli_pkg::OP_INS_AT, pli_pkg::POS_W'(pli_pkg::DEPTH + 1), rand_value());
    issue(pli_pkg::OP_INS_AT, pli_pkg::POS_W'(pli_pkg::DEPTH + 2), rand_value());
    issue(pli_pkg::OP_DUMP, '0, rand_value());
    issue(pli_pkg::OP_DEL_FRONT, '0, rand_value());
    issue(pli_pkg::OP_DEL_END, '0, rand_value());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // chunks alternate between growing, shrinking and a balanced mix
      mode = (i / CHUNK) % 3;
      tx_gaps = ((i / CHUNK) % 4 != 3);
      quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        op = pli_pkg::OP_DUMP;
      end else if (r < 11) begin
        op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      end else if (r < (mode == 0 ? 80 : (mode == 1 ? 35 : 55))) begin
        r = $urandom_range(0, 2);
        op = (r == 0) ? pli_pkg::OP_INS_FRONT :
             ((r == 1) ? pli_pkg::OP_INS_END : pli_pkg::OP_INS_AT);
      end else begin
        op = $urandom_range(0, 1) ? pli_pkg::OP_DEL_FRONT : pli_pkg::OP_DEL_END;
      end
      pos = pli_pkg::POS_W'($urandom);
      if (op == pli_pkg::OP_INS_AT) begin
        r = $urandom_range(0, 9);
        if (r == 0) pos = '0;
        else if (r == 1 && sb.count + 2 <= 63)
          pos = pli_pkg::POS_W'($urandom_range(sb.count + 2, 63));
        else pos = pli_pkg::POS_W'($urandom_range(1, sb.count + 1));
      end
      issue(op, pos, rand_value());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("positional_list_insert_delete_tb: PASS");
    end else begin
      $display("positional_list_insert_delete_tb: FAIL");
    end
    $finish;
  end

endmodule
